FILE: design/leb_pkg.sv
// Package for the LEB128 stream decoder.
// Holds the beat types, status codes and sizing constants.
// Used by leb128_stream_decoder_core; depends on nothing.
package leb_pkg;

  localparam int MAX_BYTES_DEF = 8;
  localparam int COUNT_W       = 4;
  localparam int VALUE_W       = 64;
  localparam int GROUP_W       = 7;
  localparam int LANES_ALL     = 9;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd9;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_BND = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_signed;
    logic       last_in_buffer;
  } leb_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] byte_count;
  } leb_out_t;

endpackage

FILE: design/leb128_stream_decoder_core.sv
// Top level of the LEB128 stream decoder: input register, decode logic and
// output register in one module. Depends on leb_pkg. An accepted byte is
// held in the input register and its result in the output register.
// Throughput: one byte per cycle, set by the shift-or into the accumulator.
// The input register stalls only while a result waits in a stalled output
// register. Synchronous active-low reset clears all but the data fields.
module leb128_stream_decoder_core #(
  parameter int MAX_BYTES = leb_pkg::MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  leb_pkg::leb_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output leb_pkg::leb_out_t out_data
);

  localparam int ACC_W = leb_pkg::GROUP_W * MAX_BYTES;

  logic                         s1_valid_r;
  leb_pkg::leb_in_t             s1_data_r;
  logic [ACC_W-1:0]             acc_r, acc_nxt;
  logic [leb_pkg::COUNT_W-1:0]  seen_r, seen_nxt;
  logic                         sgn_r, sgn_nxt;
  logic                         out_valid_r;
  leb_pkg::leb_out_t            out_data_r, res_nxt;

  logic                         first;
  logic                         mode;
  logic                         cont;
  logic                         has_res;
  logic                         adv;
  logic                         fill;
  logic [leb_pkg::COUNT_W-1:0]  total;
  logic [leb_pkg::COUNT_W-1:0]  shown;
  logic [leb_pkg::VALUE_W-1:0]  val;

  always_comb begin
    first   = (seen_r == '0);
    mode    = first ? s1_data_r.is_signed : sgn_r;
    cont    = s1_data_r.data_byte[7];
    acc_nxt = first ? '0 : acc_r;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (seen_r == leb_pkg::COUNT_W'(k)) begin
        acc_nxt[k*leb_pkg::GROUP_W +: leb_pkg::GROUP_W] = s1_data_r.data_byte[6:0];
      end
    end
    total = seen_r + 4'd1;
    shown = (total > leb_pkg::COUNT_SAT) ? leb_pkg::COUNT_SAT : total;

    fill = mode && s1_data_r.data_byte[6];
    val  = leb_pkg::VALUE_W'(acc_nxt);
    for (int j = 0; j < leb_pkg::LANES_ALL; j++) begin
      if (fill && (leb_pkg::COUNT_W'(j) >= total)) begin
        val[j*leb_pkg::GROUP_W +: leb_pkg::GROUP_W] = '1;
      end
    end
    val[leb_pkg::VALUE_W-1] = val[leb_pkg::VALUE_W-1] | fill;

    has_res            = 1'b1;
    res_nxt.byte_count = shown;
    res_nxt.value      = '0;
    seen_nxt           = '0;
    sgn_nxt            = mode;
    if (cont && !s1_data_r.last_in_buffer) begin
      has_res        = 1'b0;
      res_nxt.status = leb_pkg::STATUS_OK;
      seen_nxt       = shown;
    end else if (cont) begin
      res_nxt.status = leb_pkg::STATUS_OUT_OF_BND;
    end else if (total > leb_pkg::COUNT_W'(MAX_BYTES)) begin
      res_nxt.status = leb_pkg::STATUS_TOO_LONG;
    end else begin
      res_nxt.status = leb_pkg::STATUS_OK;
      res_nxt.value  = val;
    end
  end

  assign adv       = s1_valid_r && (!has_res || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
      acc_r       <= '0;
      sgn_r       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
        s1_data_r  <= in_data;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        seen_r <= seen_nxt;
        acc_r  <= acc_nxt;
        sgn_r  <= sgn_nxt;
      end
      if (adv && has_res) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != leb_pkg::STATUS_OK) |-> out_data_r.value == '0)
    else $error("error beat carries nonzero value");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.byte_count != '0) &&
                    (out_data_r.byte_count <= leb_pkg::COUNT_SAT))
    else $error("byte_count out of range");

  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == leb_pkg::STATUS_TOO_LONG)
      |-> (out_data_r.byte_count > leb_pkg::COUNT_W'(MAX_BYTES)) ||
          (out_data_r.byte_count == leb_pkg::COUNT_SAT))
    else $error("too_long reported for a short encoding");

  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= leb_pkg::COUNT_SAT)
    else $error("byte counter past saturation");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

endmodule

FILE: tb/sv/tb_leb128_stream_decoder_core.sv
// Testbench for leb128_stream_decoder_core: directed and random byte streams with
// idle, stall and long back-pressure phases, each result beat checked against a
// built-in LEB128 decoder. Depends on leb_pkg and the core module.
module tb_leb128_stream_decoder_core;

  localparam int HOLD_CYCLES = 150;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  leb_pkg::leb_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  leb_pkg::leb_out_t out_data;

  logic [leb_pkg::VALUE_W-1:0] payload_acc = '0;
  logic [leb_pkg::COUNT_W-1:0] groups_seen = '0;
  logic signed_latch = 1'b0;
  leb_pkg::leb_out_t expected_q[$];

  int mismatches = 0;
  int beats_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  leb128_stream_decoder_core i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic void decode_beat(input leb_pkg::leb_in_t b, output bit emit,
                                      output leb_pkg::leb_out_t r);
    int idx;
    int total;
    logic [leb_pkg::COUNT_W-1:0] shown;
    idx = groups_seen;
    if (idx == 0) begin
      payload_acc = '0;
      signed_latch = b.is_signed;
    end
    if (idx < leb_pkg::MAX_BYTES_DEF)
      payload_acc = payload_acc |
                    (leb_pkg::VALUE_W'(b.data_byte[6:0]) << (leb_pkg::GROUP_W * idx));
    total = idx + 1;
    shown = (total > leb_pkg::COUNT_SAT) ? leb_pkg::COUNT_SAT : leb_pkg::COUNT_W'(total);
    emit = 1'b1;
    r = '0;
    r.byte_count = shown;
    if (b.data_byte[7]) begin
      if (!b.last_in_buffer) begin
        groups_seen = shown;
        emit = 1'b0;
        return;
      end
      r.status = leb_pkg::STATUS_OUT_OF_BND;
    end else if (total > leb_pkg::MAX_BYTES_DEF) begin
      r.status = leb_pkg::STATUS_TOO_LONG;
    end else begin
      r.status = leb_pkg::STATUS_OK;
      r.value = payload_acc;
      if (signed_latch && b.data_byte[6])
        r.value = r.value | ({leb_pkg::VALUE_W{1'b1}} << (leb_pkg::GROUP_W * total));
    end
    groups_seen = '0;
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v)
      note_error($sformatf("%s expected %h actual %h", name, exp_v, act_v));
  endfunction

  always @(posedge clk) begin
    leb_pkg::leb_out_t want;
    leb_pkg::leb_out_t pred;
    bit emit;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          note_error($sformatf("result beat with nothing pending: %h", out_data));
        end else begin
          want = expected_q.pop_front();
          check_field("value", want.value, out_data.value);
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("byte_count", 64'(want.byte_count), 64'(out_data.byte_count));
        end
      end
      if (in_valid && !in_stall) begin
        decode_beat(in_data, emit, pred);
        if (emit)
          expected_q.push_back(pred);
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic sgn, input logic last);
    leb_pkg::leb_in_t b;
    b.data_byte = data;
    b.is_signed = sgn;
    b.last_in_buffer = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_value(input int len, input logic sgn, input bit cut_short);
    logic [7:0] d;
    logic last;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(127));
      last = 1'b0;
      if (i < len - 1) begin
        d[7] = 1'b1;
      end else if (cut_short) begin
        d[7] = 1'b1;
        last = 1'b1;
      end else begin
        last = 1'($urandom_range(1));
      end
      send_beat(d, (i == 0) ? sgn : 1'($urandom_range(1)), last);
    end
  endtask

  task automatic test_short_values();
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b1, 1'b0);
    send_beat(8'hC0, 1'b1, 1'b0);
    send_beat(8'hBB, 1'b0, 1'b0);
    send_beat(8'h78, 1'b0, 1'b1);
  endtask

  task automatic test_max_length();
    repeat (7) send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b0);
  endtask

  task automatic test_overlong();
    repeat (9) send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_buffer_end();
    send_beat(8'h80, 1'b0, 1'b1);
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int beats);
    int stop;
    int r;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      r = $urandom_range(99);
      if (r < 12)
        send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(7) == 0);
      else if (r < 20)
        send_value($urandom_range(1, 12), 1'($urandom_range(1)), 1'b1);
      else if (r < 30)
        send_value($urandom_range(9, 12), 1'($urandom_range(1)), 1'b0);
      else if (r < 55)
        send_value($urandom_range(1, 2), 1'($urandom_range(1)), 1'b0);
      else
        send_value($urandom_range(3, 8), 1'($urandom_range(1)), 1'b0);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    repeat (6) send_value($urandom_range(1, 8), 1'($urandom_range(1)), 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_values();
    test_max_length();
    test_overlong();
    test_buffer_end();
    test_random_mix(0, 0, 150);
    test_random_mix(61, 0, 150);
    test_random_mix(0, 61, 150);
    test_backpressure();
    test_random_mix(22, 22, 150);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
